// File: hdl/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants of the address to symbol lookup block.
// ----------------------------------------------------------------------------
package asl_pkg;

    // default table sizes
    localparam int unsigned MAX_SYMBOLS_DEF       = 4096;
    localparam int unsigned NAME_STREAM_BYTES_DEF = 65536;
    localparam int unsigned TOKEN_TEXT_BYTES_DEF  = 4096;
    localparam int unsigned NAME_MAX_DEF          = 128;

    // fixed sizes
    localparam int unsigned TOKEN_CODES = 256;
    localparam int unsigned TS_W        = 16;   // stored token start width
    localparam int unsigned T_W         = 17;   // token text pointer width
    localparam int unsigned GM_W        = 16;   // group marker width
    localparam int unsigned SC_W        = 13;   // symbol_count register width
    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned S_TDATA_W   = 152;
    localparam int unsigned M_TDATA_W   = 200;

    // request modes
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_NAME   = 3'd1;
    localparam logic [2:0] MODE_GROUP  = 3'd2;
    localparam logic [2:0] MODE_TTEXT  = 3'd3;
    localparam logic [2:0] MODE_TSTART = 3'd4;
    localparam logic [2:0] MODE_LOOKUP = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] CFG_TEXT_START   = 2'd1;
    localparam logic [1:0] CFG_TEXT_END     = 2'd2;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_NF,
        S_BS,
        S_BS_CMP,
        S_BASE,
        S_SCAN,
        S_SCAN_CMP,
        S_SIZE,
        S_GRP,
        S_REC,
        S_REC_ADD,
        S_LEN,
        S_CODE,
        S_TSRD,
        S_TSGET,
        S_TRD,
        S_TCHK,
        S_PUT,
        S_FLUSH
    } asl_state_t;

endpackage

// File: hdl/address_symbol_lookup.sv
// Operation: a lookup runs a binary search, an alias scan, a skip of up to 255 records within
// the symbol's group and a token by token name decode, all driven by the single sequencer
// walking one registered memory port per table.
// Requests: one at a time; s_tready is high only while the sequencer is idle.
// Reset: aresetn synchronous active low resets the sequencer state, output valid and config
// registers (symbol count to 1); table contents are undefined until loaded, no clearing pass.
// ----------------------------------------------------------------------------
// address_symbol_lookup
// Resolves a code address to its symbol: binary search over sorted starts,
// size and offset, then decodes the token-compressed name up to 8 bytes per result.
// ----------------------------------------------------------------------------
module address_symbol_lookup
    import asl_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS       = MAX_SYMBOLS_DEF,
    parameter int unsigned NAME_STREAM_BYTES = NAME_STREAM_BYTES_DEF,
    parameter int unsigned TOKEN_TEXT_BYTES  = TOKEN_TEXT_BYTES_DEF,
    parameter int unsigned NAME_MAX          = NAME_MAX_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_wdata,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[3], slot[16], load_value[64], lookup_address[64]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // in_text[1], symbol_size[64], symbol_offset[64],
                                            // name_bytes[64], byte_count[4]
    output logic                 m_tlast
);

    localparam int unsigned SYM_AW = $clog2(MAX_SYMBOLS);
    localparam int unsigned CNT_W  = SYM_AW + 1;
    localparam int unsigned CMP_W  = (CNT_W > SC_W) ? CNT_W : SC_W;
    localparam int unsigned NS_AW  = $clog2(NAME_STREAM_BYTES);
    localparam int unsigned POS_W  = ((NS_AW > 17) ? NS_AW : 17) + 1;
    localparam int unsigned TT_AW  = $clog2(TOKEN_TEXT_BYTES);
    localparam int unsigned GC     = (MAX_SYMBOLS + 255) / 256;
    localparam int unsigned GC_AW  = (GC > 1) ? $clog2(GC) : 1;
    localparam int unsigned N_W    = $clog2(NAME_MAX + 1);

    // request fields
    logic [2:0]  in_mode;
    logic [15:0] in_slot;
    logic [63:0] in_value;
    logic [63:0] in_addr;
    assign in_mode  = s_tdata[2:0];
    assign in_slot  = s_tdata[18:3];
    assign in_value = s_tdata[82:19];
    assign in_addr  = s_tdata[146:83];

    // memories
    logic [63:0]   start_mem [MAX_SYMBOLS];
    logic [7:0]    ns_mem    [NAME_STREAM_BYTES];
    logic [GM_W-1:0] gm_mem  [GC];
    logic [7:0]    tt_mem    [TOKEN_TEXT_BYTES];
    logic [TS_W-1:0] ts_mem  [TOKEN_CODES];

    logic [SYM_AW-1:0] sym_raddr;
    logic [POS_W-1:0]  ns_rpos;
    logic [GC_AW-1:0]  gm_raddr;
    logic [T_W-1:0]    tt_rpos;
    logic [7:0]        ts_raddr;

    logic [63:0]       sym_rdata;
    logic [7:0]        ns_rdata;
    logic              ns_oob;
    logic [GM_W-1:0]   gm_rdata;
    logic [7:0]        tt_rdata;
    logic [TS_W-1:0]   ts_rdata;
    logic [7:0]        ns_byte;

    logic              load_acc;
    assign load_acc = s_tvalid && s_tready;

    // configuration registers
    logic [SC_W-1:0] symbol_count_reg;
    logic [63:0]     text_start_reg;
    logic [63:0]     text_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= SC_W'(1);
            text_start_reg   <= '0;
            text_end_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SYMBOL_COUNT: symbol_count_reg <= cfg_wdata[SC_W-1:0];
                CFG_TEXT_START:   text_start_reg   <= cfg_wdata;
                CFG_TEXT_END:     text_end_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // table writes and registered reads
    always_ff @(posedge aclk) begin
        if (load_acc && in_mode == MODE_START && 32'(in_slot) < MAX_SYMBOLS)
            start_mem[in_slot[SYM_AW-1:0]] <= in_value;
        sym_rdata <= start_mem[sym_raddr];
    end

    always_ff @(posedge aclk) begin
        if (load_acc && in_mode == MODE_NAME && 32'(in_slot) < NAME_STREAM_BYTES)
            ns_mem[NS_AW'(in_slot)] <= in_value[7:0];
        ns_rdata <= ns_mem[ns_rpos[NS_AW-1:0]];
        ns_oob   <= (32'(ns_rpos) >= NAME_STREAM_BYTES);
    end
    assign ns_byte = ns_oob ? 8'd0 : ns_rdata;

    always_ff @(posedge aclk) begin
        if (load_acc && in_mode == MODE_GROUP && 32'(in_slot) < GC)
            gm_mem[in_slot[GC_AW-1:0]] <= in_value[GM_W-1:0];
        gm_rdata <= gm_mem[gm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (load_acc && in_mode == MODE_TTEXT && 32'(in_slot) < TOKEN_TEXT_BYTES)
            tt_mem[in_slot[TT_AW-1:0]] <= in_value[7:0];
        tt_rdata <= tt_mem[tt_rpos[TT_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (load_acc && in_mode == MODE_TSTART && 32'(in_slot) < TOKEN_CODES)
            ts_mem[in_slot[7:0]] <= in_value[TS_W-1:0];
        ts_rdata <= ts_mem[ts_raddr];
    end

    // sequencer registers
    asl_state_t        state_reg,  state_next;
    logic [63:0]       addr_reg,   addr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  low_reg,    low_next;
    logic [CNT_W-1:0]  high_reg,   high_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;
    logic [63:0]       base_reg,   base_next;
    logic [63:0]       end_reg,    end_next;
    logic [63:0]       size_reg,   size_next;
    logic [63:0]       offs_reg,   offs_next;
    logic [7:0]        k_reg,      k_next;
    logic [POS_W-1:0]  off_reg,    off_next;
    logic [7:0]        len_reg,    len_next;
    logic [T_W-1:0]    t_reg,      t_next;
    logic [7:0]        char_reg,   char_next;
    logic              skip_reg,   skip_next;
    logic [N_W-1:0]    n_reg,      n_next;
    logic [63:0]       acc_reg,    acc_next;
    logic [3:0]        acc_cnt_reg, acc_cnt_next;

    // output register
    logic              mv_reg,     mv_next;
    logic              mi_reg,     mi_next;
    logic [63:0]       ms_reg,     ms_next;
    logic [63:0]       mo_reg,     mo_next;
    logic [63:0]       mn_reg,     mn_next;
    logic [3:0]        mc_reg,     mc_next;
    logic              ml_reg,     ml_next;

    logic              out_free;
    logic [CNT_W-1:0]  count_c;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign mid_sum  = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid      = mid_sum[CNT_W:1];

    // clamp the symbol count to between 1 and the table size
    always_comb begin
        if (symbol_count_reg == '0)
            count_c = CNT_W'(1);
        else if (CMP_W'(symbol_count_reg) > CMP_W'(MAX_SYMBOLS))
            count_c = CNT_W'(MAX_SYMBOLS);
        else
            count_c = CNT_W'(symbol_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        count_reg   <= count_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        end_reg     <= end_next;
        size_reg    <= size_next;
        offs_reg    <= offs_next;
        k_reg       <= k_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        t_reg       <= t_next;
        char_reg    <= char_next;
        skip_reg    <= skip_next;
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        acc_cnt_reg <= acc_cnt_next;
        mi_reg      <= mi_next;
        ms_reg      <= ms_next;
        mo_reg      <= mo_next;
        mn_reg      <= mn_next;
        mc_reg      <= mc_next;
        ml_reg      <= ml_next;
    end

    // next state, read addresses and result pushes
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        end_next     = end_reg;
        size_next    = size_reg;
        offs_next    = offs_reg;
        k_next       = k_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        t_next       = t_reg;
        char_next    = char_reg;
        skip_next    = skip_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        mv_next      = mv_reg && !m_tready;
        mi_next      = mi_reg;
        ms_next      = ms_reg;
        mo_next      = mo_reg;
        mn_next      = mn_reg;
        mc_next      = mc_reg;
        ml_next      = ml_reg;
        sym_raddr    = low_reg[SYM_AW-1:0];
        ns_rpos      = off_reg;
        gm_raddr     = GC_AW'(low_reg >> 8);
        tt_rpos      = t_reg;
        ts_raddr     = ns_byte;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && in_mode == MODE_LOOKUP) begin
                    addr_next  = in_addr;
                    count_next = count_c;
                    low_next   = '0;
                    high_next  = count_c;
                    if (in_addr < text_start_reg || in_addr > text_end_reg)
                        state_next = S_NF;
                    else
                        state_next = S_BS;
                end
            end
            S_NF: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mi_next = 1'b0;
                    ms_next = '0;
                    mo_next = '0;
                    mn_next = '0;
                    mc_next = '0;
                    ml_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // binary search for the last start at or below the address
            S_BS: begin
                if (high_reg - low_reg > CNT_W'(1)) begin
                    sym_raddr  = mid[SYM_AW-1:0];
                    state_next = S_BS_CMP;
                end else begin
                    sym_raddr  = low_reg[SYM_AW-1:0];
                    state_next = S_BASE;
                end
            end
            S_BS_CMP: begin
                if (sym_rdata <= addr_reg)
                    low_next = mid;
                else
                    high_next = mid;
                state_next = S_BS;
            end
            S_BASE: begin
                base_next  = sym_rdata;
                end_next   = '0;
                idx_next   = low_reg + CNT_W'(1);
                state_next = S_SCAN;
            end
            // scan past aliases for the next greater start
            S_SCAN: begin
                sym_raddr = idx_reg[SYM_AW-1:0];
                if (idx_reg < count_reg)
                    state_next = S_SCAN_CMP;
                else
                    state_next = S_SIZE;
            end
            S_SCAN_CMP: begin
                if (sym_rdata > base_reg) begin
                    end_next   = sym_rdata;
                    state_next = S_SIZE;
                end else begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SIZE: begin
                size_next  = end_reg - base_reg;
                offs_next  = addr_reg - base_reg;
                k_next     = '0;
                state_next = S_GRP;
            end
            S_GRP: begin
                off_next   = POS_W'(gm_rdata);
                state_next = S_REC;
            end
            // skip records within the group
            S_REC: begin
                ns_rpos = off_reg;
                if (k_reg < low_reg[7:0])
                    state_next = S_REC_ADD;
                else
                    state_next = S_LEN;
            end
            S_REC_ADD: begin
                off_next   = off_reg + POS_W'(ns_byte) + POS_W'(1);
                k_next     = k_reg + 8'd1;
                state_next = S_REC;
            end
            S_LEN: begin
                len_next     = ns_byte;
                off_next     = off_reg + POS_W'(1);
                skip_next    = 1'b0;
                n_next       = '0;
                acc_next     = '0;
                acc_cnt_next = '0;
                state_next   = S_CODE;
            end
            // token by token decode
            S_CODE: begin
                ns_rpos = off_reg;
                if (len_reg != 8'd0)
                    state_next = S_TSRD;
                else
                    state_next = S_FLUSH;
            end
            S_TSRD: begin
                ts_raddr   = ns_byte;
                off_next   = off_reg + POS_W'(1);
                len_next   = len_reg - 8'd1;
                state_next = S_TSGET;
            end
            S_TSGET: begin
                t_next     = T_W'(ts_rdata);
                state_next = S_TRD;
            end
            S_TRD: begin
                tt_rpos = t_reg;
                if (32'(t_reg) < TOKEN_TEXT_BYTES && 32'(n_reg) < NAME_MAX - 1)
                    state_next = S_TCHK;
                else
                    state_next = S_CODE;
            end
            S_TCHK: begin
                char_next = tt_rdata;
                if (tt_rdata == 8'd0)
                    state_next = S_CODE;
                else
                    state_next = S_PUT;
            end
            S_PUT: begin
                if (!skip_reg) begin
                    skip_next  = 1'b1;
                    t_next     = t_reg + T_W'(1);
                    state_next = S_TRD;
                end else if (acc_cnt_reg == 4'd8) begin
                    // full word goes out once the next character is known
                    if (out_free) begin
                        mv_next      = 1'b1;
                        mi_next      = 1'b1;
                        ms_next      = size_reg;
                        mo_next      = offs_reg;
                        mn_next      = acc_reg;
                        mc_next      = 4'd8;
                        ml_next      = 1'b0;
                        acc_next     = {56'd0, char_reg};
                        acc_cnt_next = 4'd1;
                        n_next       = n_reg + N_W'(1);
                        t_next       = t_reg + T_W'(1);
                        state_next   = S_TRD;
                    end
                end else begin
                    acc_next[{acc_cnt_reg[2:0], 3'b000} +: 8] = char_reg;
                    acc_cnt_next = acc_cnt_reg + 4'd1;
                    n_next       = n_reg + N_W'(1);
                    t_next       = t_reg + T_W'(1);
                    state_next   = S_TRD;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mi_next    = 1'b1;
                    ms_next    = size_reg;
                    mo_next    = offs_reg;
                    mn_next    = acc_reg;
                    mc_next    = acc_cnt_reg;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result stream
    assign m_tvalid = mv_reg;
    assign m_tlast  = ml_reg;
    assign m_tdata  = {3'd0, mc_reg, mn_reg, mo_reg, ms_reg, mi_reg};

`ifndef NO_ASSERTIONS
    // a search compare only happens with a live interval
    a_bs_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BS_CMP) |-> (high_reg - low_reg > CNT_W'(1)))
        else $error("search compare outside a live interval");

    // the found index stays inside the clamped count
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BASE) |-> (low_reg < count_reg))
        else $error("found index past symbol count");

    // the word accumulator never overfills
    a_acc_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUT || state_reg == S_TRD) |-> (acc_cnt_reg <= 4'd8))
        else $error("name accumulator overfilled");

    // a flush hands over the final result of the lookup
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && out_free) |=> (m_tvalid && m_tlast))
        else $error("flush did not present a last result");
`endif

endmodule
